FILE: sv/rdx_pkg.sv
// Shared constants, types and arithmetic helpers of the radix digit converter.
package rdx_pkg;

  localparam int VALUE_W         = 64;
  localparam int RADIX_W         = 5;
  localparam int CHAR_W          = 7;
  localparam int DIGIT_W         = 4;
  localparam int MAX_DIGITS      = 64;
  localparam int DIG_AW          = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int STEP_BITS       = 8;
  localparam int STEPS_PER_DIGIT = VALUE_W / STEP_BITS;
  localparam int STEP_CW         = $clog2(STEPS_PER_DIGIT);

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0] CHAR_ALPHA   = CHAR_W'(8'h57);

  typedef struct packed {
    logic [STEP_BITS-1:0] quo;
    logic [DIGIT_W-1:0]   rem;
  } div_step_t;

  // Long division of one group of bits by the base, one bit per inner step.
  function automatic div_step_t div_step(input logic [DIGIT_W-1:0]   rem_in,
                                         input logic [STEP_BITS-1:0] bits,
                                         input logic [RADIX_W-1:0]   base);
    div_step_t          res;
    logic [DIGIT_W:0]   r5;
    logic [DIGIT_W-1:0] r4;
    r4      = rem_in;
    res.quo = '0;
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      r5 = {r4, bits[i]};
      if (r5 >= base) begin
        r5         = r5 - base;
        res.quo[i] = 1'b1;
      end
      r4 = r5[DIGIT_W-1:0];
    end
    res.rem = r4;
    return res;
  endfunction

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] b;
    b = r;
    if (b < RADIX_MIN) b = RADIX_MIN;
    if (b > RADIX_MAX) b = RADIX_MAX;
    return b;
  endfunction

  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_W'(10)) c = CHAR_ZERO + CHAR_W'(d);
    else                  c = CHAR_ALPHA + CHAR_W'(d);
    return c;
  endfunction

endpackage

FILE: sv/binary_to_radix_digits.sv
// Top level of the radix digit converter: divider sequencer, digit store and output stage.
//
// Input channel in_valid/in_ready/in_value takes one unsigned 64-bit value.
// Output channel out_valid/out_ready returns one ASCII character per digit,
// most significant first; out_last_digit marks the final character.
// cfg_we/cfg_wdata write the base; 0..1 act as 2, 17..31 act as 16.
// Write the base only while the block is idle.
// Digits come from one shared 8-bit long-division step, which walks the
// 64-bit value 8 bits at a time for each digit.
// Each digit is then shown through a store read and then the output
// register, and waits while the receiver holds out_ready low.
// in_ready is high only while idle; the next value can be taken in the cycle
// after the final digit transfers.
// A stalled receiver holds the current character in its register and
// pauses the block. Synchronous reset returns the block to idle with
// base 10; the digit store needs no clearing.
module binary_to_radix_digits (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rdx_pkg::RADIX_W-1:0]    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rdx_pkg::VALUE_W-1:0]    in_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rdx_pkg::CHAR_W-1:0]     out_digit_char,
  output logic                           out_last_digit
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_SHOW = 2'd3;

  logic [1:0]                          state_r, state_nxt;
  logic [rdx_pkg::RADIX_W-1:0]         radix_r, radix_nxt;
  logic [rdx_pkg::RADIX_W-1:0]         base;
  logic [rdx_pkg::VALUE_W-1:0]         work_r, work_nxt;
  logic [rdx_pkg::DIGIT_W-1:0]         rem_r, rem_nxt;
  logic [rdx_pkg::STEP_CW-1:0]         step_r, step_nxt;
  logic [rdx_pkg::DIG_AW-1:0]          cnt_r, cnt_nxt;
  logic [rdx_pkg::DIG_AW-1:0]          ptr_r, ptr_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic                                out_last_r, out_last_nxt;
  logic [rdx_pkg::DIGIT_W-1:0]         rd_data_r;
  logic [rdx_pkg::DIGIT_W-1:0]         digit_store [rdx_pkg::MAX_DIGITS];
  rdx_pkg::div_step_t                  step_res;
  logic [rdx_pkg::VALUE_W-1:0]         shifted;
  logic                                digit_done;
  logic                                store_we;
  logic                                in_xfer, out_xfer;

  assign base     = rdx_pkg::clamp_radix(radix_r);
  assign step_res = rdx_pkg::div_step(rem_r,
                      work_r[rdx_pkg::VALUE_W-1 -: rdx_pkg::STEP_BITS], base);
  assign shifted  = {work_r[rdx_pkg::VALUE_W-rdx_pkg::STEP_BITS-1:0], step_res.quo};
  assign digit_done = (step_r == rdx_pkg::STEP_CW'(rdx_pkg::STEPS_PER_DIGIT - 1));
  assign store_we = (state_r == ST_CONV) && digit_done;

  assign in_ready       = (state_r == ST_IDLE);
  assign in_xfer        = in_valid && in_ready;
  assign out_valid      = out_valid_r;
  assign out_xfer       = out_valid_r && out_ready;
  assign out_digit_char = rdx_pkg::glyph(rd_data_r);
  assign out_last_digit = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    radix_nxt     = cfg_we ? cfg_wdata : radix_r;
    work_nxt      = work_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          work_nxt  = in_value;
          rem_nxt   = '0;
          step_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        work_nxt = shifted;
        rem_nxt  = step_res.rem;
        step_nxt = step_r + 1'b1;
        if (digit_done) begin
          rem_nxt  = '0;
          step_nxt = '0;
          if (shifted == '0 ||
              cnt_r == rdx_pkg::DIG_AW'(rdx_pkg::MAX_DIGITS - 1)) begin
            ptr_nxt   = cnt_r;
            state_nxt = ST_READ;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ST_READ: begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = (ptr_r == '0);
        state_nxt     = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_xfer) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            ptr_nxt   = ptr_r - 1'b1;
            state_nxt = ST_READ;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      radix_r     <= rdx_pkg::RADIX_RESET;
      step_r      <= '0;
      cnt_r       <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      radix_r     <= radix_nxt;
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      digit_store[cnt_r] <= step_res.rem;
    end
    if (state_r == ST_READ) begin
      rd_data_r <= digit_store[ptr_r];
    end
  end

`ifndef SYNTHESIS
  a_busy_after_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("input taken while a conversion is in progress");

  a_no_input_while_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("ready for input while a digit is pending");

  a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV) |-> (rem_r < base))
    else $error("partial remainder not below the base");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_last_digit) |=> in_ready)
    else $error("block not idle after the final digit transfer");
`endif

endmodule

FILE: sim/rdx_digit_checker.sv
// Checker for the radix digit converter: predicts digit strings and compares each transfer.
module rdx_digit_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [rdx_pkg::RADIX_W-1:0]  cfg_wdata,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [rdx_pkg::VALUE_W-1:0]  in_value,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [rdx_pkg::CHAR_W-1:0]   out_digit_char,
  input  logic                         out_last_digit,
  output int unsigned                  digits_owed,
  output int unsigned                  fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [8*16-1:0] DIGIT_GLYPHS = "0123456789abcdef";

  typedef struct packed {
    logic [rdx_pkg::CHAR_W-1:0] ch;
    logic                       last;
  } digit_char_t;

  digit_char_t                 owed_digits[$];
  digit_char_t                 want;
  logic [rdx_pkg::RADIX_W-1:0] base_reg;
  int unsigned                 mismatches;

  function automatic void push_digits_of(input logic [rdx_pkg::VALUE_W-1:0] v,
                                         input logic [rdx_pkg::RADIX_W-1:0] r);
    logic [rdx_pkg::RADIX_W-1:0] b;
    logic [rdx_pkg::DIGIT_W-1:0] rems[rdx_pkg::MAX_DIGITS];
    logic [rdx_pkg::VALUE_W-1:0] q;
    digit_char_t                 d;
    int                          n;
    b = r;
    if (b < rdx_pkg::RADIX_MIN) b = rdx_pkg::RADIX_MIN;
    if (b > rdx_pkg::RADIX_MAX) b = rdx_pkg::RADIX_MAX;
    q = v;
    n = 0;
    do begin
      rems[n] = rdx_pkg::DIGIT_W'(q % b);
      q = q / b;
      n++;
    end while (q != 0 && n < rdx_pkg::MAX_DIGITS);
    for (int k = n - 1; k >= 0; k--) begin
      d.ch   = DIGIT_GLYPHS[8*(15 - rems[k]) +: rdx_pkg::CHAR_W];
      d.last = (k == 0);
      owed_digits.push_back(d);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      owed_digits.delete();
      base_reg    = rdx_pkg::RADIX_RESET;
      mismatches  = 0;
      digits_owed <= 0;
      fail_count  <= 0;
    end else begin
      if (in_valid && in_ready) push_digits_of(in_value, base_reg);
      if (out_valid && out_ready) begin
        if (owed_digits.size() == 0) begin
          $display("%0t: unexpected digit transfer, expected none, got char %h last %b",
                   $time, out_digit_char, out_last_digit);
          mismatches++;
        end else begin
          want = owed_digits.pop_front();
          if (out_digit_char !== want.ch) begin
            $display("%0t: digit char expected %h, got %h", $time, want.ch, out_digit_char);
            mismatches++;
          end
          if (out_last_digit !== want.last) begin
            $display("%0t: last digit flag expected %b, got %b",
                     $time, want.last, out_last_digit);
            mismatches++;
          end
        end
      end
      if (cfg_we) base_reg = cfg_wdata;
      digits_owed <= owed_digits.size();
      fail_count  <= mismatches;
    end
  end

endmodule

FILE: sim/tb_binary_to_radix_digits.sv
// Testbench top for the radix digit converter: stimulus, idling, watchdog and verdict.
module tb_binary_to_radix_digits;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  logic [rdx_pkg::RADIX_W-1:0] cfg_wdata;
  logic                        in_valid;
  logic                        in_ready;
  logic [rdx_pkg::VALUE_W-1:0] in_value;
  logic                        out_valid;
  logic                        out_ready;
  logic [rdx_pkg::CHAR_W-1:0]  out_digit_char;
  logic                        out_last_digit;
  int unsigned                 digits_owed;
  int unsigned                 fail_count;
  int unsigned                 send_idle_pct;
  int unsigned                 recv_idle_pct;
  int unsigned                 quiet_cycles;

  binary_to_radix_digits dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

  rdx_digit_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit),
    .digits_owed    (digits_owed),
    .fail_count     (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [rdx_pkg::VALUE_W-1:0] pick_value();
    logic [rdx_pkg::VALUE_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(3))
      0: v = v >> $urandom_range(63);
      1: v = v >> (56 + $urandom_range(7));
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_value(input logic [rdx_pkg::VALUE_W-1:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (digits_owed != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_radix(input logic [rdx_pkg::RADIX_W-1:0] r);
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [rdx_pkg::RADIX_W-1:0] r;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    in_value      <= '0;
    send_idle_pct = 21;
    recv_idle_pct <= 65;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // base 10 out of reset
    send_value(64'd0);
    send_value(64'd1);
    send_value(64'd9);
    send_value(64'd10);
    send_value('1);
    send_value(64'd1234567890);
    settle();
    write_radix(5'd0);
    send_value(64'd0);
    send_value(64'd1);
    send_value('1);
    send_value(64'h8000_0000_0000_0000);
    settle();
    write_radix(5'd1);
    send_value(64'd5);
    settle();
    write_radix(5'd16);
    send_value(64'd0);
    send_value('1);
    send_value(64'hfedc_ba98_7654_3210);
    settle();
    write_radix(5'd17);
    send_value(64'd255);
    settle();
    write_radix(5'd31);
    send_value(64'h0123_4567_89ab_cdef);
    settle();
    write_radix(5'd3);
    send_value('1);
    send_value(64'd2);
    settle();
    write_radix(5'd12);
    send_value(64'h5555_5555_aaaa_aaaa);
    settle();

    for (int seg = 0; seg < 9; seg++) begin
      if (seg < 3) begin
        send_idle_pct = 21;
        recv_idle_pct <= 65;
      end else if (seg < 6) begin
        send_idle_pct = 65;
        recv_idle_pct <= 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      if ($urandom_range(3) == 0) begin
        r = rdx_pkg::RADIX_W'($urandom_range(31));
      end else begin
        r = rdx_pkg::RADIX_W'($urandom_range(rdx_pkg::RADIX_MAX, rdx_pkg::RADIX_MIN));
      end
      write_radix(r);
      repeat (38) send_value(pick_value());
      settle();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/rdx_pkg.sv
sv/binary_to_radix_digits.sv
sim/rdx_digit_checker.sv
sim/tb_binary_to_radix_digits.sv
